// File: design/tpsa_pkg.sv
// Package for the TS PSI section assembler: constants, status codes, CRC step.
// Used by every module of the block; depends on nothing.
`default_nettype none
package tpsa_pkg;

  localparam int PACKET_BYTES = 188;
  localparam int POS_W = 8;
  localparam int TGT_W = 9;

  localparam logic [7:0] SYNC_VALUE = 8'h47;
  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [12:0] MAX_SIZE_RESET = 13'd4096;

  typedef enum logic [2:0] {
    ST_LONG_OK  = 3'd0,
    ST_SHORT_OK = 3'd1,
    ST_CRC_BAD  = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_ABORTED  = 3'd4
  } status_t;

  // One reassembler event handed to the output stage.
  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    logic        first;
    logic        last;
    status_t     status;
    logic [63:0] header;
  } evt_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: design/tpsa_core.sv
// Packet parser and section reassembler; one registered input beat in, one event out.
// Depends on tpsa_pkg.
`default_nettype none
module tpsa_core
  import tpsa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic [7:0]  b,
  input  wire logic        pstart,
  input  wire logic [12:0] max_size,
  output evt_t             evt
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [3:0]  last_counter, last_counter_next;
  logic        disc, disc_next;
  logic        f_live, f_pusi, f_af, f_stuff;
  logic        f_live_next, f_pusi_next, f_af_next, f_stuff_next;
  logic [TGT_W-1:0] pay_start, pay_start_next;
  logic [TGT_W-1:0] new_pos, new_pos_next;
  logic        sec_open, sec_open_next;
  logic        hdr_done, hdr_done_next;
  logic [12:0] need, need_next;
  logic [12:0] count, count_next;
  logic [31:0] crc, crc_next;
  logic [63:0] hdr, hdr_next;

  logic [TGT_W-1:0] pos;
  logic [TGT_W-1:0] tgt;
  logic [12:0] len;
  logic        do_feed;
  logic        start_new;
  logic [12:0] f_count;
  logic [31:0] f_crc;
  logic [63:0] f_hdr;
  logic [12:0] f_need;
  logic        fin;
  logic        ended;

  always_comb begin
    byte_position_next = byte_position;
    last_counter_next = last_counter;
    disc_next = disc;
    f_live_next = f_live;
    f_pusi_next = f_pusi;
    f_af_next = f_af;
    f_stuff_next = f_stuff;
    pay_start_next = pay_start;
    new_pos_next = new_pos;
    sec_open_next = sec_open;
    hdr_done_next = hdr_done;
    need_next = need;
    count_next = count;
    crc_next = crc;
    hdr_next = hdr;
    evt = '0;
    evt.status = ST_LONG_OK;
    pos = '0;
    tgt = '0;
    len = '0;
    do_feed = 1'b0;
    start_new = 1'b0;
    f_count = count;
    f_crc = crc;
    f_hdr = hdr;
    f_need = need;
    fin = 1'b0;
    ended = 1'b0;

    if (pstart) begin
      byte_position_next = '0;
      f_live_next = (b == SYNC_VALUE);
      f_pusi_next = 1'b0;
      f_af_next = 1'b0;
      f_stuff_next = 1'b0;
      pay_start_next = '0;
      new_pos_next = '0;
    end else begin
      if (byte_position < POS_W'(PACKET_BYTES)) begin
        byte_position_next = byte_position + 1'b1;
      end
      pos = TGT_W'(byte_position_next);
      if (pos >= TGT_W'(PACKET_BYTES) || !f_live) begin
      end else if (pos == TGT_W'(1)) begin
        if (b[6]) f_pusi_next = 1'b1;
      end else if (pos == TGT_W'(2)) begin
      end else if (pos == TGT_W'(3)) begin
        if (b[3:0] == last_counter && !disc) begin
          f_live_next = 1'b0;
        end else begin
          if (b[3:0] != last_counter + 4'd1) begin
            disc_next = 1'b1;
            if (sec_open) begin
              sec_open_next = 1'b0;
              hdr_done_next = 1'b0;
              need_next = '0;
              evt.valid = 1'b1;
              evt.last = 1'b1;
              evt.status = ST_ABORTED;
              evt.header = hdr;
            end
          end
          last_counter_next = b[3:0];
          if (!b[4]) begin
            f_live_next = 1'b0;
          end else if (b[5]) begin
            f_af_next = 1'b1;
            pay_start_next = TGT_W'(5);
          end else begin
            pay_start_next = TGT_W'(4);
          end
        end
      end else if (f_af && pos == TGT_W'(4)) begin
        pay_start_next = TGT_W'(5) + TGT_W'(b);
      end else if (pos < pay_start) begin
      end else if (f_pusi && pos == pay_start) begin
        tgt = pos + TGT_W'(1) + TGT_W'(b);
        new_pos_next = (tgt < TGT_W'(PACKET_BYTES)) ? tgt : '0;
        f_stuff_next = 1'b0;
      end else if (sec_open) begin
        do_feed = 1'b1;
      end else if (new_pos != '0 && pos == new_pos) begin
        new_pos_next = '0;
        f_stuff_next = 1'b0;
        if (!(f_stuff && b == FILL_BYTE)) begin
          do_feed = 1'b1;
          start_new = 1'b1;
        end
      end

      if (do_feed) begin
        if (start_new) begin
          f_count = '0;
          f_crc = '1;
          f_hdr = '0;
          f_need = 13'd3;
          hdr_done_next = 1'b0;
          sec_open_next = 1'b1;
        end
        if (f_count < 13'd8) begin
          f_hdr[8*(7-f_count[2:0]) +: 8] = b;
        end
        hdr_next = f_hdr;
        count_next = f_count + 13'd1;
        crc_next = crc_byte(f_crc, b);
        if (f_need != '0) f_need = f_need - 13'd1;
        need_next = f_need;
        evt.valid = 1'b1;
        evt.data = b;
        evt.first = (f_count == '0);
        evt.header = f_hdr;
        if (f_need == '0) begin
          if (!(hdr_done && !start_new)) begin
            hdr_done_next = 1'b1;
            len = {1'b0, f_hdr[51:48], f_hdr[47:40]};
            if (len + 13'd3 > max_size) begin
              ended = 1'b1;
              evt.last = 1'b1;
              evt.status = ST_TOO_LONG;
            end else begin
              need_next = len;
              fin = (len == '0);
            end
          end else begin
            fin = 1'b1;
          end
          if (fin) begin
            ended = 1'b1;
            evt.last = 1'b1;
            if (f_hdr[55]) begin
              evt.status = (crc_next == '0) ? ST_LONG_OK : ST_CRC_BAD;
            end else begin
              evt.status = ST_SHORT_OK;
            end
            if (evt.status != ST_CRC_BAD) disc_next = 1'b0;
          end
          if (ended) begin
            sec_open_next = 1'b0;
            hdr_done_next = 1'b0;
            need_next = '0;
            f_stuff_next = 1'b0;
            if (!(new_pos_next != '0 && new_pos_next > pos)) begin
              new_pos_next = '0;
              if (fin && pos + TGT_W'(1) < TGT_W'(PACKET_BYTES)) begin
                new_pos_next = pos + TGT_W'(1);
                f_stuff_next = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      last_counter <= '0;
      disc <= 1'b1;
      f_live <= 1'b0;
      f_pusi <= 1'b0;
      f_af <= 1'b0;
      f_stuff <= 1'b0;
      pay_start <= '0;
      new_pos <= '0;
      sec_open <= 1'b0;
      hdr_done <= 1'b0;
      need <= '0;
      count <= '0;
      crc <= '1;
      hdr <= '0;
    end else if (en) begin
      byte_position <= byte_position_next;
      last_counter <= last_counter_next;
      disc <= disc_next;
      f_live <= f_live_next;
      f_pusi <= f_pusi_next;
      f_af <= f_af_next;
      f_stuff <= f_stuff_next;
      pay_start <= pay_start_next;
      new_pos <= new_pos_next;
      sec_open <= sec_open_next;
      hdr_done <= hdr_done_next;
      need <= need_next;
      count <= count_next;
      crc <= crc_next;
      hdr <= hdr_next;
    end
  end

endmodule
`default_nettype wire

// File: design/ts_psi_section_assembler.sv
// TS PSI section assembler top level: input register, reassembler core, output register.
// An input beat is captured in the input register, and its result in the output register.
// Throughput: one input beat per cycle while in_stall is low; the output register holds a result under stall.
// Reset: synchronous, clears control state; max_size returns to 4096.
// Depends on tpsa_pkg and tpsa_core.
`default_nettype none
module ts_psi_section_assembler
  import tpsa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  packet_byte,
  input  wire logic        packet_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       section_byte,
  output logic             first_of_section,
  output logic             last_of_section,
  output logic [2:0]       section_status,
  output logic [7:0]       tbl_id,
  output logic             syntax_indicator,
  output logic [15:0]      tbl_id_ext,
  output logic [4:0]       tbl_version,
  output logic             current_next,
  output logic [7:0]       sec_index,
  output logic [7:0]       last_sec_index,
  output logic [11:0]      sec_len_field
);

  logic [12:0] max_size;
  logic        r_valid;
  logic [7:0]  r_byte;
  logic        r_start;
  logic        advance;
  evt_t        evt;
  evt_t        o;
  logic        full;

  assign advance = !(out_valid && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= MAX_SIZE_RESET;
    end else if (cfg_wr_en) begin
      max_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_byte <= packet_byte;
      r_start <= packet_start;
    end
  end

  tpsa_core u_core (
    .clk      (clk),
    .rst      (rst),
    .en       (advance && r_valid),
    .b        (r_byte),
    .pstart   (r_start),
    .max_size (max_size),
    .evt      (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= r_valid && evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o <= evt;
    end
  end

  assign full = o.last && (o.status == ST_LONG_OK);
  assign section_byte = o.data;
  assign first_of_section = o.first;
  assign last_of_section = o.last;
  assign section_status = o.status;
  assign tbl_id = o.header[63:56];
  assign syntax_indicator = o.header[55];
  assign sec_len_field = o.header[51:40];
  assign tbl_id_ext = full ? o.header[39:24] : '0;
  assign tbl_version = full ? o.header[21:17] : '0;
  assign current_next = full ? o.header[16] : 1'b0;
  assign sec_index = full ? o.header[15:8] : '0;
  assign last_sec_index = full ? o.header[7:0] : '0;

endmodule
`default_nettype wire
